### design/tfc_pkg.sv
package tfc_pkg;

	localparam logic [1:0] FMT_UNORM8 = 2'd0;
	localparam logic [1:0] FMT_HALF   = 2'd1;
	localparam logic [1:0] FMT_FP32   = 2'd2;

	localparam logic CMD_ENCODE = 1'b0;
	localparam logic CMD_DECODE = 1'b1;

	localparam logic [1:0] ERR_OK        = 2'd0;
	localparam logic [1:0] ERR_NONFINITE = 2'd1;
	localparam logic [1:0] ERR_RANGE     = 2'd2;

	localparam logic [30:0] HALF_MAX_BITS = 31'h477F_E000;

	typedef struct packed {
		logic        cmd;
		logic [31:0] chan_r;
		logic [31:0] chan_g;
		logic [31:0] chan_b;
		logic [31:0] chan_a;
	} texel_t;

	typedef struct packed {
		logic [31:0] out_r;
		logic [31:0] out_g;
		logic [31:0] out_b;
		logic [31:0] out_a;
		logic [1:0]  error_code;
	} result_t;

	typedef logic [31:0] unorm_lut_t [256];

	// n/255 as float32, round to nearest (ties cannot occur, 255 is odd)
	function automatic unorm_lut_t build_unorm_lut();
		unorm_lut_t lut;
		logic [63:0] num;
		logic [63:0] q;
		logic [63:0] rem;
		int s;
		for (int n = 0; n < 256; n++) begin
			if (n == 0) begin
				lut[n] = 32'h0;
			end else if (n == 255) begin
				lut[n] = 32'h3F80_0000;
			end else begin
				s = 8;
				for (int k = 8; k >= 1; k--) begin
					if ((n << k) >= 255) s = k;
				end
				num = 64'(n) << (23 + s);
				q = num / 64'd255;
				rem = num % 64'd255;
				if (rem * 2 > 64'd255) q = q + 64'd1;
				if (q[24]) begin
					lut[n] = {1'b0, 8'(128 - s), 23'h0};
				end else begin
					lut[n] = {1'b0, 8'(127 - s), q[22:0]};
				end
			end
		end
		return lut;
	endfunction

	localparam unorm_lut_t UNORM_LUT = build_unorm_lut();

endpackage

### design/tfc_chan.sv
module tfc_chan
	import tfc_pkg::*;
(
	input  logic [1:0]  fmt,
	input  logic        cmd,
	input  logic [31:0] chan,
	output logic [31:0] res,
	output logic [1:0]  err
);

	logic [7:0]  ex;
	logic [23:0] man;
	logic        sgn;

	// unorm encode
	logic [31:0] prod;
	logic [24:0] kept;
	logic        rnd;
	logic [33:0] rval;
	logic [5:0]  ushift;
	logic [33:0] usum;
	logic [33:0] ushifted;
	logic [7:0]  unorm_enc;

	// fp16 encode
	logic [4:0]  hshift;
	logic [24:0] hsum;
	logic [24:0] hr;
	logic [14:0] hmag;
	logic [15:0] half_enc;

	// fp16 decode
	logic [15:0] h;
	logic [3:0]  lead;
	logic [31:0] half_dec;
	logic [22:0] sub_man;

	assign sgn = chan[31];
	assign ex  = chan[30:23];
	assign man = {1'b1, chan[22:0]};

	always_comb begin
		prod = 32'(man) * 32'd255;
		if (prod[31]) begin
			kept = {1'b0, prod[31:8]};
			rnd  = prod[7] & ((|prod[6:0]) | prod[8]);
			rval = {9'd0, kept + 25'(rnd)} << 8;
		end else begin
			kept = {1'b0, prod[30:7]};
			rnd  = prod[6] & ((|prod[5:0]) | prod[7]);
			rval = {9'd0, kept + 25'(rnd)} << 7;
		end
		// exponent 118..126 here, so the shift is 24..32
		ushift   = 6'(8'd150 - ex);
		usum     = rval + (34'd1 << (ushift - 6'd1));
		ushifted = usum >> ushift;
		if (sgn || ex < 8'd118) begin
			unorm_enc = 8'd0;
		end else if (ex >= 8'd127) begin
			unorm_enc = 8'd255;
		end else begin
			unorm_enc = ushifted[7:0];
		end
	end

	always_comb begin
		hshift = (ex < 8'd113) ? 5'(8'd126 - ex) : 5'd13;
		hsum = 25'(man) + ((25'd1 << (hshift - 5'd1)) - 25'd1)
			+ 25'((man >> hshift) & 24'd1);
		hr = hsum >> hshift;
		hmag = (15'(ex - 8'd113) << 10) + hr[14:0];
		if (ex < 8'd102) begin
			half_enc = {sgn, 15'd0};
		end else if (ex < 8'd113) begin
			half_enc = {sgn, hr[14:0]};
		end else begin
			half_enc = {sgn, hmag};
		end
	end

	always_comb begin
		h = chan[15:0];
		lead = 4'd0;
		for (int i = 0; i < 10; i++) begin
			if (h[i]) lead = 4'(i);
		end
		sub_man = 23'({13'd0, h[9:0]} << (5'd23 - 5'(lead)));
		if (h[14:10] == 5'd31) begin
			half_dec = {h[15], (h[9:0] != 10'd0) ? 31'h7FC0_0000 : 31'h7F80_0000};
		end else if (h[14:10] != 5'd0) begin
			half_dec = {h[15], 8'(h[14:10]) + 8'd112, h[9:0], 13'd0};
		end else if (h[9:0] == 10'd0) begin
			half_dec = {h[15], 31'd0};
		end else begin
			half_dec = {h[15], 8'(lead) + 8'd103, sub_man};
		end
	end

	always_comb begin
		err = ERR_OK;
		res = chan;
		if (cmd == CMD_DECODE) begin
			case (fmt)
				FMT_UNORM8: res = UNORM_LUT[chan[7:0]];
				FMT_HALF:   res = half_dec;
				default:    res = chan;
			endcase
		end else begin
			if (ex == 8'hFF) begin
				err = ERR_NONFINITE;
			end else if (fmt == FMT_HALF && chan[30:0] > HALF_MAX_BITS) begin
				err = ERR_RANGE;
			end
			case (fmt)
				FMT_UNORM8: res = {24'd0, unorm_enc};
				FMT_HALF:   res = {16'd0, half_enc};
				default:    res = chan;
			endcase
		end
	end

endmodule

### design/texel_format_converter_unit.sv
// Texel format converter: one texel in, one result out.
// Two registers: an input register, then a result register after the channel logic.
// Throughput one texel per cycle while result_stall does not hold the pipeline; the four channels convert in parallel.
// arst_n clears the valid bits and sets the format register fmt_q to unorm8 (FMT_UNORM8).
module texel_format_converter_unit
	import tfc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_data,
	input  logic       texel_valid,
	output logic       texel_stall,
	input  texel_t     texel,
	output logic       result_valid,
	input  logic       result_stall,
	output result_t    result
);

	logic [1:0] fmt_q;
	logic       v_s1;
	texel_t     texel_s1;
	logic       v_s2;
	result_t    result_s2;
	logic       adv_s2;
	logic       adv_s1;
	logic [31:0] res [4];
	logic [1:0]  err [4];
	logic [1:0]  err_any;
	result_t     next_res;

	assign cfg_ready    = 1'b1;
	assign adv_s2       = !v_s2 || !result_stall;
	assign adv_s1       = !v_s1 || adv_s2;
	assign texel_stall  = !adv_s1;
	assign result_valid = v_s2;
	assign result       = result_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_UNORM8;
		end else if (cfg_valid) begin
			fmt_q <= cfg_data;
		end
	end

	tfc_chan u_chan_r (.fmt(fmt_q), .cmd(texel_s1.cmd), .chan(texel_s1.chan_r),
		.res(res[0]), .err(err[0]));
	tfc_chan u_chan_g (.fmt(fmt_q), .cmd(texel_s1.cmd), .chan(texel_s1.chan_g),
		.res(res[1]), .err(err[1]));
	tfc_chan u_chan_b (.fmt(fmt_q), .cmd(texel_s1.cmd), .chan(texel_s1.chan_b),
		.res(res[2]), .err(err[2]));
	tfc_chan u_chan_a (.fmt(fmt_q), .cmd(texel_s1.cmd), .chan(texel_s1.chan_a),
		.res(res[3]), .err(err[3]));

	// first failing channel in r, g, b, a order decides
	always_comb begin
		err_any = ERR_OK;
		for (int i = 3; i >= 0; i--) begin
			if (err[i] != ERR_OK) err_any = err[i];
		end
		if (err_any != ERR_OK) begin
			next_res = '{out_r: 32'd0, out_g: 32'd0, out_b: 32'd0, out_a: 32'd0,
				error_code: err_any};
		end else begin
			next_res = '{out_r: res[0], out_g: res[1], out_b: res[2], out_a: res[3],
				error_code: ERR_OK};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= texel_valid;
			if (adv_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && texel_valid) texel_s1 <= texel;
		if (adv_s2 && v_s1) result_s2 <= next_res;
	end

endmodule

### tb/sv/texel_format_converter_unit_tb.sv
module texel_format_converter_unit_tb;
	import tfc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_data = FMT_UNORM8;
	logic       texel_valid = 1'b0;
	logic       texel_stall;
	texel_t     texel = '0;
	logic       result_valid;
	logic       result_stall = 1'b0;
	result_t    result;

	texel_t  pending_texels[$];
	result_t expected_results[$];
	logic [1:0] fmt_copy = FMT_UNORM8;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatches = 0;
	int results_seen = 0;
	int texels_sent = 0;

	texel_format_converter_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.texel_valid  (texel_valid),
		.texel_stall  (texel_stall),
		.texel        (texel),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// n/255 as float32, round to nearest
	function automatic logic [31:0] unorm_to_float(logic [7:0] n);
		logic [63:0] num;
		logic [63:0] q;
		int s;
		if (n == 8'd0) return 32'h0;
		if (n == 8'd255) return 32'h3F80_0000;
		s = 1;
		while ((int'(n) << s) < 255) s++;
		num = 64'(n) << (23 + s);
		q = num / 64'd255;
		if ((num % 64'd255) * 2 > 64'd255) q++;
		if (q[24]) return {1'b0, 8'(128 - s), 23'h0};
		return {1'b0, 8'(127 - s), q[22:0]};
	endfunction

	function automatic logic [31:0] half_to_float(logic [15:0] h);
		logic [31:0] sgn;
		logic [4:0] ex;
		logic [9:0] fr;
		int p;
		sgn = {h[15], 31'h0};
		ex = h[14:10];
		fr = h[9:0];
		if (ex == 5'd31) return sgn | (fr != 0 ? 32'h7FC0_0000 : 32'h7F80_0000);
		if (ex != 5'd0) return sgn | (32'(ex + 8'd112) << 23) | (32'(fr) << 13);
		if (fr == 10'd0) return sgn;
		p = 9;
		while (fr[p] == 1'b0) p--;
		return sgn | (32'(p + 103) << 23) | ((32'(fr) << (23 - p)) & 32'h7F_FFFF);
	endfunction

	function automatic logic [31:0] float_to_half(logic [31:0] b);
		logic [31:0] sgn;
		logic [31:0] m;
		logic [31:0] r;
		int e;
		int sh;
		sgn = {16'h0, b[31], 15'h0};
		e = int'(b[30:23]) - 127;
		m = {8'h0, 1'b1, b[22:0]};
		if (e < -25) return sgn;
		sh = (e < -14) ? (-e - 1) : 13;
		r = (m + ((32'd1 << (sh - 1)) - 32'd1) + ((m >> sh) & 32'd1)) >> sh;
		if (e < -14) return sgn | r;
		return sgn | ((32'(e + 14) << 10) + r);
	endfunction

	// clamp, multiply by 255 with float32 rounding, round half away from zero
	function automatic logic [31:0] float_to_unorm(logic [31:0] b);
		logic [63:0] mant;
		logic [63:0] prod;
		logic [63:0] rr;
		logic [63:0] rem;
		logic [63:0] fixp;
		int ex;
		int msb;
		int s;
		int sh;
		if (b[31] && b[30:0] != 0) return 32'd0;
		if (b[30:0] > 31'h3F80_0000) return 32'd255;
		if (b[30:0] == 0) return 32'd0;
		mant = (b[30:23] == 0) ? 64'(b[22:0]) : 64'({1'b1, b[22:0]});
		ex = ((b[30:23] == 0) ? 1 : int'(b[30:23])) - 150;
		prod = mant * 64'd255;
		msb = 63;
		while (prod[msb] == 1'b0) msb--;
		s = (msb > 23) ? msb - 23 : 0;
		rr = prod >> s;
		if (s > 0) begin
			rem = prod & ((64'd1 << s) - 64'd1);
			if (rem > (64'd1 << (s - 1)) || (rem == (64'd1 << (s - 1)) && rr[0])) rr++;
		end
		sh = ex + s;
		if (sh >= 0) return 32'((rr << sh) & 64'hFF);
		if (sh < -40) return 32'd0;
		fixp = rr << (40 + sh);
		return 32'(((fixp >> 40) + (fixp[39] ? 64'd1 : 64'd0)) & 64'hFF);
	endfunction

	function automatic result_t convert_texel(texel_t t, logic [1:0] fmt);
		logic [31:0] ch[4];
		logic [31:0] res[4];
		logic [1:0] err;
		result_t r;
		ch[0] = t.chan_r;
		ch[1] = t.chan_g;
		ch[2] = t.chan_b;
		ch[3] = t.chan_a;
		err = ERR_OK;
		for (int i = 0; i < 4; i++) begin
			res[i] = 32'h0;
			if (t.cmd == CMD_DECODE) begin
				if (fmt == FMT_UNORM8) res[i] = unorm_to_float(ch[i][7:0]);
				else if (fmt == FMT_HALF) res[i] = half_to_float(ch[i][15:0]);
				else res[i] = ch[i];
			end else if (err == ERR_OK) begin
				if (ch[i][30:23] == 8'hFF) err = ERR_NONFINITE;
				else if (fmt == FMT_HALF && ch[i][30:0] > HALF_MAX_BITS) err = ERR_RANGE;
				else if (fmt == FMT_UNORM8) res[i] = float_to_unorm(ch[i]);
				else if (fmt == FMT_HALF) res[i] = float_to_half(ch[i]);
				else res[i] = ch[i];
			end
		end
		r.out_r = (err != ERR_OK) ? 32'h0 : res[0];
		r.out_g = (err != ERR_OK) ? 32'h0 : res[1];
		r.out_b = (err != ERR_OK) ? 32'h0 : res[2];
		r.out_a = (err != ERR_OK) ? 32'h0 : res[3];
		r.error_code = err;
		return r;
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (texel_valid && !texel_stall) begin
				expected_results.push_back(convert_texel(texel, fmt_copy));
				texels_sent++;
			end
			if (!texel_valid || !texel_stall) begin
				if (pending_texels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					texel <= pending_texels.pop_front();
					texel_valid <= 1'b1;
				end else begin
					texel_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result %h", result);
				end else begin
					want = expected_results.pop_front();
					if (want.out_r !== result.out_r || want.out_g !== result.out_g ||
							want.out_b !== result.out_b || want.out_a !== result.out_a ||
							want.error_code !== result.error_code) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch exp r=%h g=%h b=%h a=%h err=%0d got r=%h g=%h b=%h a=%h err=%0d",
								want.out_r, want.out_g, want.out_b, want.out_a, want.error_code,
								result.out_r, result.out_g, result.out_b, result.out_a,
								result.error_code);
					end
				end
			end
			result_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	function automatic texel_t mk(logic cmd, logic [31:0] r, logic [31:0] g,
			logic [31:0] b, logic [31:0] a);
		texel_t t;
		t.cmd = cmd;
		t.chan_r = r;
		t.chan_g = g;
		t.chan_b = b;
		t.chan_a = a;
		return t;
	endfunction

	function automatic logic [31:0] rand_chan(logic cmd);
		logic [31:0] v;
		v = $urandom;
		if (cmd == CMD_DECODE) begin
			if ($urandom_range(3) == 0) v[14:10] = $urandom_range(1) ? 5'd31 : 5'd0;
			return v;
		end
		case ($urandom_range(7))
			0, 1: ;
			2: v[30:23] = 8'(110 + $urandom_range(17));
			3: v[30:23] = 8'(100 + $urandom_range(45));
			4: v[30:23] = 8'(140 + $urandom_range(5));
			5: v[30:23] = $urandom_range(1) ? 8'hFF : 8'h00;
			6: v[30:23] = 8'(118 + $urandom_range(9));
			default: v = {1'b0, 8'(120 + $urandom_range(7)), v[22:0]};
		endcase
		return v;
	endfunction

	task automatic queue_random(int n);
		logic cmd;
		for (int i = 0; i < n; i++) begin
			cmd = 1'($urandom_range(1));
			pending_texels.push_back(mk(cmd, rand_chan(cmd), rand_chan(cmd),
				rand_chan(cmd), rand_chan(cmd)));
		end
	endtask

	task automatic queue_directed();
		pending_texels.push_back(mk(CMD_ENCODE, 32'h0, 32'h8000_0000, 32'h3F80_0000, 32'h3F80_0001));
		pending_texels.push_back(mk(CMD_ENCODE, 32'hBF80_0000, 32'h3F00_0000, 32'h3B00_0000,
			32'h3C00_8081));
		pending_texels.push_back(mk(CMD_ENCODE, 32'h477F_E000, 32'hC77F_E000, 32'h3300_0000,
			32'h3300_0001));
		pending_texels.push_back(mk(CMD_ENCODE, 32'h3380_0000, 32'h3880_0000, 32'h387F_FFFF,
			32'h0000_0001));
		pending_texels.push_back(mk(CMD_ENCODE, 32'h3F80_0000, 32'h477F_E001, 32'h7F80_0000, 32'h0));
		pending_texels.push_back(mk(CMD_ENCODE, 32'h7FC0_0000, 32'h477F_F000, 32'h0, 32'h0));
		pending_texels.push_back(mk(CMD_ENCODE, 32'h0, 32'h0, 32'h0, 32'hFF80_0000));
		pending_texels.push_back(mk(CMD_ENCODE, 32'hFFFF_FFFF, 32'h7F7F_FFFF, 32'h0, 32'h0));
		pending_texels.push_back(mk(CMD_DECODE, 32'h0000_7C00, 32'h0000_7E00, 32'h0000_FC01,
			32'h0000_8000));
		pending_texels.push_back(mk(CMD_DECODE, 32'h0000_0001, 32'h0000_03FF, 32'hFFFF_FFFF,
			32'h0000_7BFF));
		pending_texels.push_back(mk(CMD_DECODE, 32'h0, 32'h0000_0080, 32'hABCD_0001, 32'h0000_00FE));
	endtask

	task automatic write_format(logic [1:0] f);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= f;
		do @(posedge clk); while (!cfg_ready);
		fmt_copy = f;
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		while (pending_texels.size() != 0 || expected_results.size() != 0 || texel_valid)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		logic [1:0] fmts[12];
		fmts = '{FMT_UNORM8, FMT_HALF, FMT_FP32, 2'd3, FMT_HALF, FMT_UNORM8,
			FMT_FP32, FMT_HALF, FMT_UNORM8, 2'd3, FMT_HALF, FMT_UNORM8};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		for (int ph = 0; ph < 12; ph++) begin
			send_idle_pct = (ph < 4) ? 11 : (ph < 8) ? 84 : 0;
			recv_stall_pct = (ph < 4) ? 84 : (ph < 8) ? 11 : 0;
			// first phase runs on the reset format
			if (ph != 0) write_format(fmts[ph]);
			if (ph < 4) queue_directed();
			queue_random(84);
			drain();
		end
		$display("covered %0d texels, %0d results, all four format settings, encode and decode",
			texels_sent, results_seen);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("tb: failure");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("tb: failure");
		$finish;
	end

endmodule

### texel_format_converter_unit.f
design/tfc_pkg.sv
design/tfc_chan.sv
design/texel_format_converter_unit.sv
tb/sv/texel_format_converter_unit_tb.sv
